FILE: rtl/rectilinear_bilinear_interpolator_defines.svh
// Assertion macros used by the interpolator checker
`ifndef RECTILINEAR_BILINEAR_INTERPOLATOR_DEFINES_SVH
`define RECTILINEAR_BILINEAR_INTERPOLATOR_DEFINES_SVH

// same-cycle implication
`define RBI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RBI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rbi_pkg.sv
// Types and constants of the rectilinear bilinear interpolator
package rbi_pkg;

    localparam int MAX_R   = 64;
    localparam int MAX_Z   = 64;
    localparam int IDX_W   = 6;                      // axis index width (field width)
    localparam int CNT_W   = 7;                      // point count width
    localparam int TBL_D   = MAX_R * MAX_Z;
    localparam int TBL_AW  = $clog2(TBL_D);
    localparam int VAL_W   = 32;
    localparam int DIF_W   = VAL_W + 1;              // coordinate difference
    localparam int PAIR_W  = 2 * DIF_W;              // product of two differences
    localparam int MA_W    = DIF_W + 1;              // multiplier operand a
    localparam int PROD_W  = MA_W + DIF_W;           // multiplier product
    localparam int NUM_W   = 101;                    // numerator accumulator
    localparam int QUO_W   = 31;
    localparam int SUM_W   = VAL_W + 2;
    localparam int STEP_W  = 4;
    localparam int LAST_STEP = 13;
    localparam int PAIR_STEP = 5;

    typedef enum logic [1:0] {
        OP_LOAD_R = 2'd0,
        OP_LOAD_Z = 2'd1,
        OP_LOAD_T = 2'd2,
        OP_QUERY  = 2'd3
    } t_opcode;

    typedef enum logic {
        CFG_R_POINTS = 1'b0,
        CFG_Z_POINTS = 1'b1
    } t_cfg_index;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHK,
        ST_FETCH,
        ST_DIFF,
        ST_MUL,
        ST_DECIDE,
        ST_DIV,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_res;

endpackage

FILE: rtl/rbi_div.sv
// Serial restoring divider of magnitudes with saturation at 31 bits
module rbi_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [rbi_pkg::NUM_W-1:0]  i_num,
    input  logic signed [rbi_pkg::PAIR_W-1:0] i_den,
    output rbi_pkg::t_div_res                 o_res
);

    localparam int REM_W = rbi_pkg::NUM_W - 1;
    localparam int DSH_W = rbi_pkg::PAIR_W - 1 + rbi_pkg::QUO_W;
    localparam int CNT_W = $clog2(rbi_pkg::QUO_W + 2);
    localparam logic [CNT_W-1:0] FIRST = CNT_W'(rbi_pkg::QUO_W + 1);

    logic [rbi_pkg::NUM_W-1:0]  w_num_abs;
    logic [rbi_pkg::PAIR_W-1:0] w_den_abs;
    logic                       w_ge;

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic [REM_W-1:0]           r_rem;
    logic [DSH_W-1:0]           r_dsh;
    logic [rbi_pkg::QUO_W-1:0]  r_quo;

    assign w_num_abs = i_num[rbi_pkg::NUM_W-1] ? -i_num : i_num;
    assign w_den_abs = i_den[rbi_pkg::PAIR_W-1] ? -i_den : i_den;
    assign w_ge      = r_rem >= REM_W'(r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= FIRST;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                // first step only tests for overflow of the 31-bit quotient
                if ((r_cnt == FIRST && w_ge) || r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= w_num_abs[REM_W-1:0];
            r_dsh <= {w_den_abs[rbi_pkg::PAIR_W-2:0], {rbi_pkg::QUO_W{1'b0}}};
            r_quo <= '0;
        end else if (r_busy) begin
            r_dsh <= r_dsh >> 1;
            if (r_cnt == FIRST) begin
                if (w_ge) begin
                    r_quo <= '1;
                end
            end else begin
                if (w_ge) begin
                    r_rem <= r_rem - REM_W'(r_dsh);
                end
                r_quo <= {r_quo[rbi_pkg::QUO_W-2:0], w_ge};
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.quo  = r_quo;

endmodule

FILE: rtl/rectilinear_bilinear_interpolator.sv
// Bilinear interpolator on a non-uniform rectilinear grid (top level)
// Loads leave ready high; a query holds ready low until its result loads.
// Query: scan (counts clamped to 64), check, fetch, differences, a multiply sequence on one
// shared 34x33 multiplier, decide, divider (cut short when the quotient saturates), result.
// Zero area or opposite signs skip the divider; outside: check to result; empty axis: result.
// Output stalls hold the result state. Sync active-low reset clears control and counts only.
module rectilinear_bilinear_interpolator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [rbi_pkg::CNT_W-1:0]          i_cfg_data,
    // input transaction
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_opcode,
    input  logic [rbi_pkg::IDX_W-1:0]          i_row_index,
    input  logic [rbi_pkg::IDX_W-1:0]          i_column_index,
    input  logic signed [rbi_pkg::VAL_W-1:0]   i_load_value,
    input  logic signed [rbi_pkg::VAL_W-1:0]   i_query_r,
    input  logic signed [rbi_pkg::VAL_W-1:0]   i_query_z,
    // result transaction
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [rbi_pkg::QUO_W-1:0]          o_interpolated_value
);

    localparam int IW = rbi_pkg::IDX_W;
    localparam int CW = rbi_pkg::CNT_W;
    localparam int VW = rbi_pkg::VAL_W;
    localparam int DW = rbi_pkg::DIF_W;
    localparam int PW = rbi_pkg::PAIR_W;
    localparam int NW = rbi_pkg::NUM_W;
    localparam int SW = rbi_pkg::STEP_W;

    // ---------------- configuration ----------------
    logic [CW-1:0] r_r_points;
    logic [CW-1:0] r_z_points;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_points <= '0;
            r_z_points <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rbi_pkg::CFG_R_POINTS: r_r_points <= i_cfg_data;
                rbi_pkg::CFG_Z_POINTS: r_z_points <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective point counts, clamped to the axis depth
    logic [CW-1:0] w_nr;
    logic [CW-1:0] w_nz;
    logic [CW-1:0] w_nmax;

    assign w_nr   = (r_r_points > CW'(rbi_pkg::MAX_R)) ? CW'(rbi_pkg::MAX_R) : r_r_points;
    assign w_nz   = (r_z_points > CW'(rbi_pkg::MAX_Z)) ? CW'(rbi_pkg::MAX_Z) : r_z_points;
    assign w_nmax = (w_nr > w_nz) ? w_nr : w_nz;

    // ---------------- state ----------------
    rbi_pkg::t_state r_state;
    rbi_pkg::t_state n_state;

    logic w_in_acc;
    assign o_in_ready = (r_state == rbi_pkg::ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;

    // ---------------- memories ----------------
    logic signed [VW-1:0] mem_rax [rbi_pkg::MAX_R];
    logic signed [VW-1:0] mem_zax [rbi_pkg::MAX_Z];
    logic signed [VW-1:0] mem_tbl [rbi_pkg::TBL_D];

    logic [IW-1:0]              w_rax_addr;
    logic [IW-1:0]              w_zax_addr;
    logic [rbi_pkg::TBL_AW-1:0] w_tbl_addr;
    logic [rbi_pkg::TBL_AW-1:0] w_tbl_waddr;
    logic signed [VW-1:0]       r_rax_q;
    logic signed [VW-1:0]       r_zax_q;
    logic signed [VW-1:0]       r_tbl_q;

    assign w_tbl_waddr = rbi_pkg::TBL_AW'(i_row_index) * rbi_pkg::TBL_AW'(rbi_pkg::MAX_R)
                       + rbi_pkg::TBL_AW'(i_column_index);

    // loads write only in idle, queries read only outside idle: no same-entry overlap
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_opcode == rbi_pkg::OP_LOAD_R
            && CW'(i_column_index) < CW'(rbi_pkg::MAX_R)) begin
            mem_rax[i_column_index] <= i_load_value;
        end
        r_rax_q <= mem_rax[w_rax_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_opcode == rbi_pkg::OP_LOAD_Z
            && CW'(i_row_index) < CW'(rbi_pkg::MAX_Z)) begin
            mem_zax[i_row_index] <= i_load_value;
        end
        r_zax_q <= mem_zax[w_zax_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_opcode == rbi_pkg::OP_LOAD_T) begin
            mem_tbl[w_tbl_waddr] <= i_load_value;
        end
        r_tbl_q <= mem_tbl[w_tbl_addr];
    end

    // ---------------- query datapath registers ----------------
    logic signed [VW-1:0] r_qr;
    logic signed [VW-1:0] r_qz;

    // scan: r_k issues reads, r_pidx tags the registered data that they return
    logic [CW-1:0] r_k;
    logic          r_pv;
    logic [CW-1:0] r_pidx;
    logic          r_rfound;
    logic          r_zfound;
    logic [IW-1:0] r_ir;
    logic [IW-1:0] r_iz;
    logic signed [VW-1:0] r_ra0;
    logic signed [VW-1:0] r_ralast;
    logic signed [VW-1:0] r_za0;
    logic signed [VW-1:0] r_zalast;

    // bracketing cell
    logic [IW-1:0] r_r1;
    logic [IW-1:0] r_r2;
    logic [IW-1:0] r_z1;
    logic [IW-1:0] r_z2;
    logic [2:0]    r_f;
    logic signed [VW-1:0] r_rlo;
    logic signed [VW-1:0] r_rhi;
    logic signed [VW-1:0] r_zlo;
    logic signed [VW-1:0] r_zhi;
    logic signed [VW-1:0] r_q [4];          // Q11, Q21, Q12, Q22

    // differences
    logic signed [DW-1:0] r_d_r;            // R2 - R1
    logic signed [DW-1:0] r_d_z;            // Z2 - Z1
    logic signed [DW-1:0] r_dr_hi;          // R2 - r
    logic signed [DW-1:0] r_dr_lo;          // r - R1
    logic signed [DW-1:0] r_dz_hi;          // Z2 - z
    logic signed [DW-1:0] r_dz_lo;          // z - Z1

    // multiply sequence
    logic [SW-1:0]                      r_s;
    logic signed [rbi_pkg::PROD_W-1:0]  r_prod;
    logic signed [PW-1:0]               r_den;
    logic signed [PW-1:0]               r_pair [4];
    logic signed [NW-1:0]               r_acc;

    logic [rbi_pkg::QUO_W-1:0] r_res;
    logic                      r_out_valid;
    logic [rbi_pkg::QUO_W-1:0] r_out_val;

    // ---------------- combinational helpers ----------------
    logic          w_scan_last;
    logic          w_outside;
    logic [IW-1:0] w_r1;
    logic [IW-1:0] w_r2;
    logic [IW-1:0] w_z1;
    logic [IW-1:0] w_z2;
    logic          w_empty;

    assign w_empty     = (w_nr == '0) || (w_nz == '0);
    assign w_scan_last = r_pv && (r_pidx == w_nmax - 1'b1);
    assign w_outside   = (r_qr < r_ra0) || (r_qr > r_ralast)
                      || (r_qz < r_za0) || (r_qz > r_zalast);

    // lower index is one below the lower bound; upper one above, clamped to the end
    assign w_r1 = (r_ir != '0) ? r_ir - 1'b1 : '0;
    assign w_z1 = (r_iz != '0) ? r_iz - 1'b1 : '0;
    assign w_r2 = (CW'(w_r1) + 1'b1 < w_nr) ? w_r1 + 1'b1 : IW'(w_nr - 1'b1);
    assign w_z2 = (CW'(w_z1) + 1'b1 < w_nz) ? w_z1 + 1'b1 : IW'(w_nz - 1'b1);

    // multiplier operand selection
    logic [SW-1:0]                     w_cs;
    logic [1:0]                        w_cj;
    logic signed [PW-1:0]              w_pp;
    logic signed [rbi_pkg::MA_W-1:0]   w_ma;
    logic signed [DW-1:0]              w_mb;

    assign w_cs = r_s - SW'(rbi_pkg::PAIR_STEP);
    assign w_cj = w_cs[2:1];
    assign w_pp = r_pair[w_cj];

    always_comb begin
        unique case (r_s)
            SW'(0): begin w_ma = {r_d_r[DW-1], r_d_r};     w_mb = r_d_z;   end
            SW'(1): begin w_ma = {r_dr_hi[DW-1], r_dr_hi}; w_mb = r_dz_hi; end
            SW'(2): begin w_ma = {r_dr_lo[DW-1], r_dr_lo}; w_mb = r_dz_hi; end
            SW'(3): begin w_ma = {r_dr_hi[DW-1], r_dr_hi}; w_mb = r_dz_lo; end
            SW'(4): begin w_ma = {r_dr_lo[DW-1], r_dr_lo}; w_mb = r_dz_lo; end
            default: begin
                // pair = hi * 2^33 + lo, lo taken as unsigned
                w_ma = w_cs[0] ? {w_pp[PW-1], w_pp[PW-1:DW]} : {1'b0, w_pp[DW-1:0]};
                w_mb = {r_q[w_cj][VW-1], r_q[w_cj]};
            end
        endcase
    end

    // zero-area fallback: floor of the corner average, zero when the sum is negative
    logic signed [rbi_pkg::SUM_W-1:0] w_qsum;
    logic [rbi_pkg::QUO_W-1:0]        w_avg;
    logic                             w_den_zero;
    logic                             w_sign_diff;

    assign w_qsum = rbi_pkg::SUM_W'(r_q[0]) + rbi_pkg::SUM_W'(r_q[1])
                  + rbi_pkg::SUM_W'(r_q[2]) + rbi_pkg::SUM_W'(r_q[3]);
    assign w_avg  = w_qsum[rbi_pkg::SUM_W-1] ? '0 : w_qsum[rbi_pkg::QUO_W+1:2];
    assign w_den_zero  = (r_den == '0);
    assign w_sign_diff = r_acc[NW-1] != r_den[PW-1];

    // divider
    logic              w_div_start;
    rbi_pkg::t_div_res w_div;

    rbi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_acc),
        .i_den   (r_den),
        .o_res   (w_div)
    );

    // ---------------- state machine ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rbi_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    logic w_out_load;

    always_comb begin
        n_state     = r_state;
        w_rax_addr  = r_k[IW-1:0];
        w_zax_addr  = r_k[IW-1:0];
        w_tbl_addr  = rbi_pkg::TBL_AW'(r_f[1] ? r_z2 : r_z1)
                      * rbi_pkg::TBL_AW'(rbi_pkg::MAX_R)
                    + rbi_pkg::TBL_AW'(r_f[0] ? r_r2 : r_r1);
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            rbi_pkg::ST_IDLE: begin
                if (w_in_acc && i_opcode == rbi_pkg::OP_QUERY) begin
                    n_state = w_empty ? rbi_pkg::ST_RESULT : rbi_pkg::ST_SCAN;
                end
            end
            rbi_pkg::ST_SCAN: begin
                if (w_scan_last) begin
                    n_state = rbi_pkg::ST_CHK;
                end
            end
            rbi_pkg::ST_CHK: begin
                n_state = w_outside ? rbi_pkg::ST_RESULT : rbi_pkg::ST_FETCH;
            end
            rbi_pkg::ST_FETCH: begin
                w_rax_addr = (r_f == 3'd0) ? r_r1 : r_r2;
                w_zax_addr = (r_f == 3'd0) ? r_z1 : r_z2;
                if (r_f == 3'd4) begin
                    n_state = rbi_pkg::ST_DIFF;
                end
            end
            rbi_pkg::ST_DIFF: begin
                n_state = rbi_pkg::ST_MUL;
            end
            rbi_pkg::ST_MUL: begin
                if (r_s == SW'(rbi_pkg::LAST_STEP)) begin
                    n_state = rbi_pkg::ST_DECIDE;
                end
            end
            rbi_pkg::ST_DECIDE: begin
                if (w_den_zero || w_sign_diff) begin
                    n_state = rbi_pkg::ST_RESULT;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = rbi_pkg::ST_DIV;
                end
            end
            rbi_pkg::ST_DIV: begin
                if (w_div.done) begin
                    n_state = rbi_pkg::ST_RESULT;
                end
            end
            rbi_pkg::ST_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_out_load = 1'b1;
                    n_state    = rbi_pkg::ST_IDLE;
                end
            end
            default: n_state = rbi_pkg::ST_IDLE;
        endcase
    end

    // ---------------- query datapath ----------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            rbi_pkg::ST_IDLE: begin
                r_qr     <= i_query_r;
                r_qz     <= i_query_z;
                r_k      <= '0;
                r_pv     <= 1'b0;
                r_rfound <= 1'b0;
                r_zfound <= 1'b0;
                r_res    <= '0;
            end
            rbi_pkg::ST_SCAN: begin
                r_pv   <= r_k < w_nmax;
                r_pidx <= r_k;
                if (r_k < w_nmax) begin
                    r_k <= r_k + 1'b1;
                end
                if (r_pv && r_pidx < w_nr) begin
                    if (r_pidx == '0) begin
                        r_ra0 <= r_rax_q;
                    end
                    if (r_pidx == w_nr - 1'b1) begin
                        r_ralast <= r_rax_q;
                    end
                    // first entry >= r, or the last valid entry
                    if (!r_rfound && (r_rax_q >= r_qr || r_pidx == w_nr - 1'b1)) begin
                        r_rfound <= 1'b1;
                        r_ir     <= r_pidx[IW-1:0];
                    end
                end
                if (r_pv && r_pidx < w_nz) begin
                    if (r_pidx == '0) begin
                        r_za0 <= r_zax_q;
                    end
                    if (r_pidx == w_nz - 1'b1) begin
                        r_zalast <= r_zax_q;
                    end
                    if (!r_zfound && (r_zax_q >= r_qz || r_pidx == w_nz - 1'b1)) begin
                        r_zfound <= 1'b1;
                        r_iz     <= r_pidx[IW-1:0];
                    end
                end
            end
            rbi_pkg::ST_CHK: begin
                r_r1 <= w_r1;
                r_r2 <= w_r2;
                r_z1 <= w_z1;
                r_z2 <= w_z2;
                r_f  <= '0;
            end
            rbi_pkg::ST_FETCH: begin
                r_f <= r_f + 1'b1;
                unique case (r_f)
                    3'd1: begin
                        r_rlo  <= r_rax_q;
                        r_zlo  <= r_zax_q;
                        r_q[0] <= r_tbl_q;
                    end
                    3'd2: begin
                        r_rhi  <= r_rax_q;
                        r_zhi  <= r_zax_q;
                        r_q[1] <= r_tbl_q;
                    end
                    3'd3: r_q[2] <= r_tbl_q;
                    3'd4: r_q[3] <= r_tbl_q;
                    default: ;
                endcase
            end
            rbi_pkg::ST_DIFF: begin
                r_d_r   <= DW'(r_rhi) - DW'(r_rlo);
                r_d_z   <= DW'(r_zhi) - DW'(r_zlo);
                r_dr_hi <= DW'(r_rhi) - DW'(r_qr);
                r_dr_lo <= DW'(r_qr)  - DW'(r_rlo);
                r_dz_hi <= DW'(r_zhi) - DW'(r_qz);
                r_dz_lo <= DW'(r_qz)  - DW'(r_zlo);
                r_s     <= '0;
                r_acc   <= '0;
            end
            rbi_pkg::ST_MUL: begin
                r_s    <= r_s + 1'b1;
                r_prod <= w_ma * w_mb;
                // consume the product issued one step earlier
                if (r_s == SW'(1)) begin
                    r_den <= r_prod[PW-1:0];
                end else if (r_s >= SW'(2) && r_s <= SW'(rbi_pkg::PAIR_STEP)) begin
                    r_pair[2'(r_s - SW'(2))] <= r_prod[PW-1:0];
                end else if (r_s > SW'(rbi_pkg::PAIR_STEP)) begin
                    if (r_s[0]) begin
                        r_acc <= r_acc + {r_prod[rbi_pkg::PROD_W-1], r_prod, {DW{1'b0}}};
                    end else begin
                        r_acc <= r_acc + NW'(r_prod);
                    end
                end
            end
            rbi_pkg::ST_DECIDE: begin
                r_res <= w_den_zero ? w_avg : '0;
            end
            rbi_pkg::ST_DIV: begin
                r_res <= w_div.quo;
            end
            rbi_pkg::ST_RESULT: ;
            default: ;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_val <= r_res;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_interpolated_value = r_out_val;

endmodule

FILE: rtl/rbi_checker.sv
// Port-level checker for the interpolator, bound to the top level
`include "rectilinear_bilinear_interpolator_defines.svh"

module rbi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [1:0]  i_opcode,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [30:0] o_interpolated_value
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && o_in_ready;

    `RBI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_interpolated_value), "result changed while stalled")
    `RBI_ASSERT_NEXT(a_load_one_cycle, i_clk, i_rst_n, w_in_acc && i_opcode != rbi_pkg::OP_QUERY, o_in_ready, "load transaction held the block busy")
    `RBI_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, w_in_acc && i_opcode == rbi_pkg::OP_QUERY, !o_in_ready, "query did not occupy the block")
    `RBI_ASSERT_NOW(a_result_after_work, i_clk, i_rst_n, $rose(o_out_valid), !$past(o_in_ready), "result appeared without a query in flight")

endmodule

bind rectilinear_bilinear_interpolator rbi_checker u_rbi_checker (.*);

FILE: tb/testbench.sv
// Self-checking testbench for the rectilinear bilinear interpolator
`timescale 1ns / 100ps

module testbench;

    // ------------------------------------------------------------------
    // Clock, reset and the inputs of the block
    // ------------------------------------------------------------------
    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic                             i_cfg_index = 1'b0;
    logic [rbi_pkg::CNT_W-1:0]        i_cfg_data = '0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_ready;
    logic [1:0]                       i_opcode = rbi_pkg::OP_LOAD_R;
    logic [rbi_pkg::IDX_W-1:0]        i_row_index = '0;
    logic [rbi_pkg::IDX_W-1:0]        i_column_index = '0;
    logic signed [rbi_pkg::VAL_W-1:0] i_load_value = '0;
    logic signed [rbi_pkg::VAL_W-1:0] i_query_r = '0;
    logic signed [rbi_pkg::VAL_W-1:0] i_query_z = '0;
    logic                             o_out_valid;
    logic                             i_out_ready = 1'b0;
    logic [rbi_pkg::QUO_W-1:0]        o_interpolated_value;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    rectilinear_bilinear_interpolator uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_opcode             (i_opcode),
        .i_row_index          (i_row_index),
        .i_column_index       (i_column_index),
        .i_load_value         (i_load_value),
        .i_query_r            (i_query_r),
        .i_query_z            (i_query_z),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_interpolated_value (o_interpolated_value)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the grid, used to predict the queries
    // ------------------------------------------------------------------
    logic signed [31:0] radial_mem   [rbi_pkg::MAX_R];
    logic signed [31:0] vertical_mem [rbi_pkg::MAX_Z];
    logic signed [31:0] field_mem    [rbi_pkg::MAX_Z][rbi_pkg::MAX_R];
    bit                 cell_written [rbi_pkg::MAX_Z][rbi_pkg::MAX_R];
    logic [rbi_pkg::CNT_W-1:0] radial_count = '0;
    logic [rbi_pkg::CNT_W-1:0] vertical_count = '0;

    logic [rbi_pkg::QUO_W-1:0] expected_values[$];
    int                 mismatches = 0;
    bit                 quiet = 1'b0;      // no idle cycles on either side

    function automatic int eff_count(logic [rbi_pkg::CNT_W-1:0] c, int lim);
        return (int'(c) > lim) ? lim : int'(c);
    endfunction

    // lower corner index along one axis (first entry >= x, stepped back one)
    function automatic int lower_corner(bit vert, int n, longint x);
        int i;
        i = 0;
        while (i + 1 < n) begin
            if ((vert ? longint'(vertical_mem[i]) : longint'(radial_mem[i])) >= x)
                break;
            i++;
        end
        return (i > 0) ? i - 1 : 0;
    endfunction

    function automatic bit outside_grid(longint r, longint z);
        int nr, nz;
        nr = eff_count(radial_count, rbi_pkg::MAX_R);
        nz = eff_count(vertical_count, rbi_pkg::MAX_Z);
        if (nr == 0 || nz == 0) return 1'b1;
        return r < radial_mem[0] || r > radial_mem[nr-1] ||
               z < vertical_mem[0] || z > vertical_mem[nz-1];
    endfunction

    function automatic logic signed [127:0] wide(longint v);
        return v;
    endfunction

    function automatic logic [rbi_pkg::QUO_W-1:0] predict_field(longint r, longint z);
        int nr, nz, r1, r2, z1, z2;
        longint lr1, lr2, lz1, lz2, q11, q21, q12, q22, s;
        logic signed [127:0] num, den, quo;
        nr = eff_count(radial_count, rbi_pkg::MAX_R);
        nz = eff_count(vertical_count, rbi_pkg::MAX_Z);
        if (outside_grid(r, z)) return '0;
        r1 = lower_corner(1'b0, nr, r);
        z1 = lower_corner(1'b1, nz, z);
        r2 = (r1 + 1 < nr) ? r1 + 1 : nr - 1;
        z2 = (z1 + 1 < nz) ? z1 + 1 : nz - 1;
        lr1 = radial_mem[r1];   lr2 = radial_mem[r2];
        lz1 = vertical_mem[z1]; lz2 = vertical_mem[z2];
        q11 = field_mem[z1][r1]; q21 = field_mem[z1][r2];
        q12 = field_mem[z2][r1]; q22 = field_mem[z2][r2];
        den = wide(lr2 - lr1) * wide(lz2 - lz1);
        if (den == 0) begin
            // degenerate cell: plain average of the corners
            s = q11 + q21 + q12 + q22;
            return (s < 0) ? '0 : rbi_pkg::QUO_W'(s / 4);
        end
        num = wide(q11) * wide(lr2 - r) * wide(lz2 - z)
            + wide(q21) * wide(r - lr1) * wide(lz2 - z)
            + wide(q12) * wide(lr2 - r) * wide(z - lz1)
            + wide(q22) * wide(r - lr1) * wide(z - lz1);
        quo = num / den;                       // truncates toward zero
        if (quo <= 0) return '0;
        if (quo > 128'sh7FFF_FFFF) return '1;
        return quo[rbi_pkg::QUO_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_item(rbi_pkg::t_opcode op, int row, int col, logic [31:0] val,
                             logic [31:0] qr, logic [31:0] qz,
                             bit typed = 1'b0,
                             logic [rbi_pkg::QUO_W-1:0] typed_value = '0);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_opcode       <= op;
        i_row_index    <= rbi_pkg::IDX_W'(row);
        i_column_index <= rbi_pkg::IDX_W'(col);
        i_load_value   <= val;
        i_query_r      <= qr;
        i_query_z      <= qz;
        i_in_valid     <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        // transaction accepted at this edge: update the shadow grid or queue the prediction
        case (op)
            rbi_pkg::OP_LOAD_R: radial_mem[col] = val;
            rbi_pkg::OP_LOAD_Z: vertical_mem[row] = val;
            rbi_pkg::OP_LOAD_T: begin
                field_mem[row][col] = val;
                cell_written[row][col] = 1'b1;
            end
            default: expected_values.push_back(typed ? typed_value :
                         predict_field(longint'($signed(qr)), longint'($signed(qz))));
        endcase
    endtask

    function automatic logic [31:0] rand_field_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return $urandom;
            default: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 18));
        endcase
    endfunction

    // a query inside the grid has its four corners loaded; any that are missing go first
    task automatic send_query(logic [31:0] qr, logic [31:0] qz);
        int nr, nz, r1, r2, z1, z2;
        nr = eff_count(radial_count, rbi_pkg::MAX_R);
        nz = eff_count(vertical_count, rbi_pkg::MAX_Z);
        if (!outside_grid(longint'($signed(qr)), longint'($signed(qz)))) begin
            r1 = lower_corner(1'b0, nr, longint'($signed(qr)));
            z1 = lower_corner(1'b1, nz, longint'($signed(qz)));
            r2 = (r1 + 1 < nr) ? r1 + 1 : nr - 1;
            z2 = (z1 + 1 < nz) ? z1 + 1 : nz - 1;
            foreach (cell_written[zz, rr])
                if ((zz == z1 || zz == z2) && (rr == r1 || rr == r2) &&
                    !cell_written[zz][rr])
                    send_item(rbi_pkg::OP_LOAD_T, zz, rr, rand_field_value(),
                              $urandom, $urandom);
        end
        send_item(rbi_pkg::OP_QUERY, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom, qr, qz);
    endtask

    // sorted axis with random spacing; zero spacing now and then, saturating at the top
    task automatic load_axis(bit vert, longint start, longint max_step);
        longint v;
        v = start;
        for (int i = 0; i < 64; i++) begin
            send_item(vert ? rbi_pkg::OP_LOAD_Z : rbi_pkg::OP_LOAD_R, i, i, 32'(v),
                      $urandom, $urandom);
            if ($urandom_range(0, 7) != 0) v += $urandom_range(1, 32'(max_step));
            if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
        end
    endtask

    function automatic logic [31:0] rand_coord(bit vert);
        int n;
        longint lo, hi, span;
        n = vert ? eff_count(vertical_count, rbi_pkg::MAX_Z)
                 : eff_count(radial_count, rbi_pkg::MAX_R);
        if (n == 0) return $urandom;
        lo = vert ? vertical_mem[0] : radial_mem[0];
        hi = vert ? vertical_mem[n-1] : radial_mem[n-1];
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 32'(lo - $urandom_range(0, 2));
            2:       return 32'(hi + $urandom_range(0, 2));
            default: begin
                if (hi < lo) return $urandom;
                span = hi - lo + 1;
                return 32'(lo + longint'({$urandom, $urandom} % span));
            end
        endcase
    endfunction

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_values.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_counts(int nr, int nz);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= rbi_pkg::CFG_R_POINTS;
        i_cfg_data  <= rbi_pkg::CNT_W'(nr);
        @(posedge i_clk);
        radial_count = rbi_pkg::CNT_W'(nr);
        i_cfg_index <= rbi_pkg::CFG_Z_POINTS;
        i_cfg_data  <= rbi_pkg::CNT_W'(nz);
        @(posedge i_clk);
        vertical_count = rbi_pkg::CNT_W'(nz);
        i_cfg_we    <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Directed rows: grid after setup is r = i, z = 1.5*i (Q16.16), 8 x 8
    // ------------------------------------------------------------------
    typedef struct {
        rbi_pkg::t_opcode          op;
        int                        row;
        int                        col;
        logic [31:0]               val;
        logic [31:0]               qr;
        logic [31:0]               qz;
        bit                        typed;
        logic [rbi_pkg::QUO_W-1:0] result;
    } t_directed_row;

    localparam int NUM_DIRECTED = 24;
    t_directed_row directed_rows[NUM_DIRECTED] = '{
        '{rbi_pkg::OP_QUERY,  0, 0, 0, 32'hFFFF_FFFF, 0, 1, 0},    // left of r span
        '{rbi_pkg::OP_QUERY,  0, 0, 0, 0, 32'h8000_0000, 1, 0},    // most negative z
        '{rbi_pkg::OP_QUERY,  0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0},
        '{rbi_pkg::OP_QUERY,  0, 0, 0, 32'h0007_0000, 32'h000A_8000, 0, 0}, // far corner
        '{rbi_pkg::OP_QUERY,  0, 0, 0, 0, 0, 0, 0},                 // near corner
        '{rbi_pkg::OP_QUERY,  0, 0, 0, 32'h0001_8000, 32'h0002_C000, 0, 0},
        '{rbi_pkg::OP_LOAD_T, 0, 0, 32'h8000_0000, 0, 0, 0, 0},
        '{rbi_pkg::OP_LOAD_T, 0, 1, 32'h8000_0000, 0, 0, 0, 0},
        '{rbi_pkg::OP_LOAD_T, 1, 0, 32'h8000_0000, 0, 0, 0, 0},
        '{rbi_pkg::OP_LOAD_T, 1, 1, 32'h8000_0000, 0, 0, 0, 0},
        '{rbi_pkg::OP_QUERY,  0, 0, 0, 32'h0000_4000, 32'h0000_4000, 1, 0}, // clamps
        '{rbi_pkg::OP_LOAD_T, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0},
        '{rbi_pkg::OP_LOAD_T, 0, 1, 32'h7FFF_FFFF, 0, 0, 0, 0},
        '{rbi_pkg::OP_LOAD_T, 1, 0, 32'h7FFF_FFFF, 0, 0, 0, 0},
        '{rbi_pkg::OP_LOAD_T, 1, 1, 32'h7FFF_FFFF, 0, 0, 0, 0},
        '{rbi_pkg::OP_QUERY,  0, 0, 0, 32'h0000_8000, 32'h0000_8000, 0, 0}, // largest
        '{rbi_pkg::OP_LOAD_R, 0, 1, 0, 0, 0, 0, 0},                 // duplicate r entry
        '{rbi_pkg::OP_QUERY,  0, 0, 0, 0, 32'h0000_8000, 0, 0},     // zero-area cell
        '{rbi_pkg::OP_LOAD_R, 0, 1, 32'h0001_0000, 0, 0, 0, 0},
        '{rbi_pkg::OP_LOAD_Z, 2, 0, 32'h7FFF_FFFF, 0, 0, 0, 0},     // unsorted z axis
        '{rbi_pkg::OP_QUERY,  0, 0, 0, 32'h0001_0000, 32'h0005_0000, 0, 0},
        '{rbi_pkg::OP_LOAD_Z, 2, 0, 32'h0003_0000, 0, 0, 0, 0},
        '{rbi_pkg::OP_LOAD_T, 63, 63, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0},
        '{rbi_pkg::OP_QUERY,  63, 63, 32'hFFFF_FFFF, 32'h0006_8000, 32'h0008_0000, 0, 0}
    };

    // configuration sweep: (radial count, vertical count) per phase
    localparam int NUM_PHASES = 10;
    int phase_nr[NUM_PHASES] = '{8, 1, 2, 64, 127, 3, 0, 5, 40, 64};
    int phase_nz[NUM_PHASES] = '{8, 1, 6, 64, 100, 2, 5, 0, 3, 127};

    // ------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty grid after reset: any query reads as zero
        send_query(32'h0, 32'h0);
        wait_idle();
        write_counts(8, 8);
        for (int i = 0; i < 64; i++) begin
            send_item(rbi_pkg::OP_LOAD_R, $urandom_range(0, 63), i, 32'(i << 16),
                      $urandom, $urandom);
            send_item(rbi_pkg::OP_LOAD_Z, i, $urandom_range(0, 63), 32'((i * 3) << 15),
                      $urandom, $urandom);
        end
        for (int zz = 0; zz < 8; zz++)
            for (int rr = 0; rr < 8; rr++)
                send_item(rbi_pkg::OP_LOAD_T, zz, rr, rand_field_value(),
                          $urandom, $urandom);

        foreach (directed_rows[k])
            send_item(directed_rows[k].op, directed_rows[k].row, directed_rows[k].col,
                      directed_rows[k].val, directed_rows[k].qr, directed_rows[k].qz,
                      directed_rows[k].typed, directed_rows[k].result);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            write_counts(phase_nr[p], phase_nz[p]);
            quiet = (p % 3 == 1);
            // fresh axes for some phases; the extremes span the full range
            case (p)
                3: begin
                    load_axis(1'b0, -64'sh8000_0000, 64'sh0800_0000);
                    load_axis(1'b1, -64'sh8000_0000, 64'sh0800_0000);
                end
                5: begin
                    load_axis(1'b0, -64'sh0001_0000, 64'sh0000_0004);
                    load_axis(1'b1, 64'sh0000_1000, 64'sh0000_0100);
                end
                8: for (int i = 0; i < 8; i++) begin
                    // unsorted axes
                    send_item(rbi_pkg::OP_LOAD_R, 0, i, $urandom, $urandom, $urandom);
                    send_item(rbi_pkg::OP_LOAD_Z, i, 0, $urandom, $urandom, $urandom);
                end
                9: begin
                    load_axis(1'b0, -64'sh0010_0000, 64'sh0004_0000);
                    load_axis(1'b1, 64'sh0000_0000, 64'sh0008_0000);
                end
                default: ;
            endcase
            for (int n = 0; n < 70; n++) begin
                int nr, nz;
                nr = eff_count(radial_count, rbi_pkg::MAX_R);
                nz = eff_count(vertical_count, rbi_pkg::MAX_Z);
                case ($urandom_range(0, 19))
                    0: send_item(rbi_pkg::OP_LOAD_R, $urandom_range(0, 63),
                                 $urandom_range(0, 63),
                                 radial_mem[0] + 32'($urandom_range(0, 3)),
                                 $urandom, $urandom);
                    1: send_item(rbi_pkg::OP_LOAD_Z, $urandom_range(0, 63),
                                 $urandom_range(0, 63), $urandom, $urandom, $urandom);
                    2, 3, 4, 5, 6:
                        send_item(rbi_pkg::OP_LOAD_T,
                                  $urandom_range(0, (nz > 1) ? nz - 1 : 63),
                                  $urandom_range(0, (nr > 1) ? nr - 1 : 63),
                                  rand_field_value(), $urandom, $urandom);
                    default: send_query(rand_coord(1'b0), rand_coord(1'b1));
                endcase
            end
        end

        i_in_valid <= 1'b0;
        while (expected_values.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side: random stalls, then compare against the oldest prediction
    // ------------------------------------------------------------------
    initial begin
        int stall;
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_rst_n));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_values.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %0d", o_interpolated_value);
            end else begin
                if (o_interpolated_value !== expected_values[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("interpolated_value mismatch: expected %0d, got %0d",
                                 expected_values[0], o_interpolated_value);
                end
                void'(expected_values.pop_front());
            end
        end
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/rbi_pkg.sv
rtl/rbi_div.sv
rtl/rectilinear_bilinear_interpolator.sv
rtl/rbi_checker.sv
tb/testbench.sv
